### src/fpconv_pkg.sv
// ----------------------------------------------------------------------------
// fpconv_pkg
// shared constants and conversion functions for the binary32/binary16 converter
// ----------------------------------------------------------------------------
package fpconv_pkg;

    typedef logic [31:0] t_word;

    // mode codes
    localparam logic MODE_S2H = 1'b0;
    localparam logic MODE_H2S = 1'b1;

    // field constants
    localparam logic [7:0] SGL_EXP_MAX   = 8'hff;
    localparam logic [4:0] HALF_EXP_MAX  = 5'h1f;
    localparam logic [9:0] HALF_MANT_MAX = 10'h3ff;
    localparam int         SGL_BIAS      = 127;
    localparam int         HALF_BIAS     = 15;

    // single exponent where the half exponent reaches zero, and where it overflows
    localparam logic [7:0] S2H_EXP_ZERO  = 8'(SGL_BIAS - HALF_BIAS);
    localparam logic [7:0] S2H_EXP_OVF   = 8'(SGL_BIAS - HALF_BIAS + 31);
    // at or below this the subnormal shift is past the 11-bit mantissa
    localparam logic [7:0] S2H_EXP_FLUSH = 8'(SGL_BIAS - HALF_BIAS - 10);
    // single exponent of a half subnormal whose leading one is at bit 0
    localparam logic [7:0] H2S_SUB_BASE  = 8'(SGL_BIAS - HALF_BIAS - 9);

    // single to half, truncating, saturating to signed infinity
    function automatic t_word f_s2h(input t_word x);
        logic        sign;
        logic [7:0]  exp8;
        logic [9:0]  mant;
        logic [7:0]  sh_full;
        logic [10:0] shifted;
        logic [4:0]  hexp;
        t_word       res;
        sign    = x[31];
        exp8    = x[30:23];
        mant    = x[22:13];
        sh_full = S2H_EXP_ZERO + 8'd1 - exp8;
        shifted = {1'b1, mant} >> sh_full[3:0];
        hexp    = 5'(exp8 - S2H_EXP_ZERO);
        if (exp8 <= S2H_EXP_FLUSH) begin
            res = {16'b0, sign, 15'b0};
        end else if (exp8 <= S2H_EXP_ZERO) begin
            res = {16'b0, sign, 5'b0, shifted[9:0]};
        end else if (exp8 >= S2H_EXP_OVF) begin
            res = {16'b0, sign, HALF_EXP_MAX, 10'b0};
        end else begin
            res = {16'b0, sign, hexp, mant};
        end
        return res;
    endfunction

    // half to single, exact
    function automatic t_word f_h2s(input logic [15:0] h);
        logic       sign;
        logic [4:0] hexp;
        logic [9:0] mant;
        logic [3:0] pos;
        logic [3:0] shamt;
        logic [9:0] nmant;
        t_word      res;
        sign  = h[15];
        hexp  = h[14:10];
        mant  = h[9:0];
        // leading-one search over the subnormal mantissa
        pos   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (mant[i]) pos = 4'(i);
        end
        shamt = 4'd10 - pos;
        nmant = mant << shamt;
        if (hexp == 5'd0) begin
            if (mant == 10'd0) begin
                res = {sign, 31'b0};
            end else begin
                res = {sign, H2S_SUB_BASE + {4'b0, pos}, nmant, 13'b0};
            end
        end else if (hexp == HALF_EXP_MAX) begin
            res = {sign, SGL_EXP_MAX, mant, 13'b0};
        end else begin
            res = {sign, {3'b0, hexp} + S2H_EXP_ZERO, mant, 13'b0};
        end
        return res;
    endfunction

endpackage

### src/fp32_fp16_converter_top.sv
// ----------------------------------------------------------------------------
// fp32_fp16_converter_top
// Converts one bit pattern per item between IEEE binary32 and binary16.
// i_mode 0 turns a single into a half (truncating, overflow, infinity and NaN
// go to signed infinity, tiny values to half subnormals or signed zero), the
// half lands in o_result_bits[15:0] with the upper half zero. i_mode 1 turns
// the half in i_operand_bits[15:0] into the exact single, keeping zero,
// infinity and NaN payload and normalizing subnormals. The block takes one
// item every cycle while the output is not stalled. An item is captured in
// the input register, then the conversion logic fills the result register,
// from which it leaves when the output takes it. Backpressure on the output
// stalls both stages together once both hold an item; an empty stage is
// always refilled, so no bubble is lost.
// ----------------------------------------------------------------------------
module fp32_fp16_converter_top
    import fpconv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [31:0] i_operand_bits,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_bits
);

    // input register stage
    logic  r_s1_valid;
    logic  r_s1_mode;
    t_word r_s1_operand;

    // result register stage
    logic  r_out_valid;
    logic  r_out_mode;
    t_word r_out_result;

    logic  s2_advance;   // result stage loads or empties this cycle
    logic  s1_advance;   // input stage loads a new item or empties this cycle
    t_word n_out_result;

    // result stage moves when it is empty or its item is being taken
    assign s2_advance = !r_out_valid || i_out_ready;
    // input stage can take an item when empty or passing its item on
    assign s1_advance = !r_s1_valid || s2_advance;
    assign o_in_ready = s1_advance;

    // the conversion itself, between the two registers
    always_comb begin
        unique case (r_s1_mode)
            MODE_S2H: n_out_result = f_s2h(r_s1_operand);
            MODE_H2S: n_out_result = f_h2s(r_s1_operand[15:0]);
            default:  n_out_result = f_s2h(r_s1_operand);
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_advance) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s1_advance && i_in_valid) begin
            r_s1_mode    <= i_mode;
            r_s1_operand <= i_operand_bits;
        end
        if (s2_advance && r_s1_valid) begin
            r_out_mode   <= r_s1_mode;
            r_out_result <= n_out_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_bits = r_out_result;

`ifndef ASSERT_OFF
    // an accepted item always occupies the input stage next cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_s1_valid)
        else $error("accepted item not captured");

    // a held item in the input stage is not dropped or altered
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_advance) |=> (r_s1_valid && $stable(r_s1_operand)))
        else $error("input stage item lost while stalled");

    // half results keep the upper half clear
    a_half_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_S2H) |-> (r_out_result[31:16] == 16'd0))
        else $error("half result has upper bits set");

    // single to half never produces a NaN
    a_no_half_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_S2H && r_out_result[14:10] == HALF_EXP_MAX)
        |-> (r_out_result[9:0] == 10'd0))
        else $error("half NaN produced");

    // half to single exponents stay in the reachable set
    a_h2s_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_mode == MODE_H2S)
        |-> (r_out_result[30:23] == 8'd0 || r_out_result[30:23] == SGL_EXP_MAX ||
             (r_out_result[30:23] >= H2S_SUB_BASE && r_out_result[30:23] <= S2H_EXP_OVF)))
        else $error("single exponent out of half range");
`endif

endmodule
